FILE: rtl/dorc_pkg.sv
`timescale 1ns / 1ps

package dorc_pkg;

    // Channel count bounds and the default build.
    localparam int CHANNELS_DEFAULT = 4;
    localparam int CHANNELS_MAX     = 8;

    // Field widths.
    localparam int DELAY_W     = 16;
    localparam int CHAN_W      = 3;
    localparam int RELAY_W     = 4;
    localparam int ACTION_W    = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 8;

    // Number of delay registers on the configuration port.
    localparam int REG_COUNT = 4;

    // Switch-on delays after reset, in millisecond ticks.
    localparam logic [DELAY_W-1:0] DELAY_FAST = 16'd50;
    localparam logic [DELAY_W-1:0] DELAY_SLOW = 16'd1000;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK    = 2'd0,
        ACT_REQUEST = 2'd1,
        ACT_SENSOR  = 2'd2,
        ACT_SPARE   = 2'd3
    } action_t;

    // Command from the decoder to one channel timer.
    typedef struct packed {
        logic tick;
        logic req;
        logic on;
    } chan_cmd_t;

    // Status of one channel timer.
    typedef struct packed {
        logic applied_next;
        logic applied;
        logic armed;
    } chan_stat_t;

    // One result word.
    typedef struct packed {
        logic               bad;
        logic [RELAY_W-1:0] relay;
    } result_t;

    // Channels 0 to 2 start fast; channel 3 and any beyond it start slow.
    function automatic logic [DELAY_W-1:0] chan_reset_delay(input int ch);
        logic [DELAY_W-1:0] d;
        d = (ch < 3) ? DELAY_FAST : DELAY_SLOW;
        return d;
    endfunction

endpackage

FILE: rtl/dorc_chan.sv
`timescale 1ns / 1ps

module dorc_chan #(
    parameter logic [dorc_pkg::DELAY_W-1:0] RESET_DELAY = dorc_pkg::DELAY_SLOW
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  dorc_pkg::chan_cmd_t          cmd,
    input  logic                         wr_en,
    input  logic [dorc_pkg::DELAY_W-1:0] wr_data,
    output dorc_pkg::chan_stat_t         stat
);

    logic [dorc_pkg::DELAY_W-1:0] delay_reg,   delay_next;
    logic [dorc_pkg::DELAY_W-1:0] elapsed_reg, elapsed_next;
    logic                         armed_reg,   armed_next;
    logic                         applied_reg, applied_next;
    logic [dorc_pkg::DELAY_W-1:0] elapsed_inc;

    // Saturating count of ticks since arming.
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg
                                             : elapsed_reg + dorc_pkg::DELAY_W'(1);

    always_comb begin
        delay_next   = wr_en ? wr_data : delay_reg;
        elapsed_next = elapsed_reg;
        armed_next   = armed_reg;
        applied_next = applied_reg;
        if (cmd.tick && armed_reg) begin
            elapsed_next = elapsed_inc;
            if (elapsed_inc >= delay_reg) begin
                armed_next   = 1'b0;
                applied_next = 1'b1;
            end
        end else if (cmd.req) begin
            if (!cmd.on) begin
                armed_next   = 1'b0;
                applied_next = 1'b0;
            end else if (!applied_reg && !armed_reg) begin
                // A repeated on request leaves a running delay alone.
                armed_next   = 1'b1;
                elapsed_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg   <= RESET_DELAY;
            elapsed_reg <= '0;
            armed_reg   <= 1'b0;
            applied_reg <= 1'b0;
        end else begin
            delay_reg   <= delay_next;
            elapsed_reg <= elapsed_next;
            armed_reg   <= armed_next;
            applied_reg <= applied_next;
        end
    end

    assign stat.applied_next = applied_next;
    assign stat.applied      = applied_reg;
    assign stat.armed        = armed_reg;

endmodule

FILE: rtl/delayed_on_relay_channels_core.sv
`timescale 1ns / 1ps
// Each result word is registered in the output stage and offered from its head slot.
// Throughput: one word per cycle while skid is free; all channel timers update in parallel.
// A two-entry output stage lets one more input word in while a result waits to be taken.
// Reset (aresetn low at a clock edge): relays off, nothing armed, counts zero,
// delays back to 50, 50, 50 and 1000 ticks, and the output stage empty.

module delayed_on_relay_channels_core #(
    parameter int CHANNELS = dorc_pkg::CHANNELS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // Input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata, lowest bit first: channel [2:0], turn_on [3], level1_good [4],
    // level2_good [5], zero padding [7:6].
    input  logic [dorc_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: action [1:0].
    input  logic [dorc_pkg::ACTION_W-1:0]    s_tuser,

    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata, lowest bit first: relay_bits [3:0], zero padding [7:4].
    output logic [dorc_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: bad_channel [0].
    output logic [0:0]                       m_tuser,

    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dorc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dorc_pkg::DELAY_W-1:0]     cfg_data
);

    // Unpacked input fields.
    dorc_pkg::action_t                action;
    logic [dorc_pkg::CHAN_W-1:0]      channel;
    logic                             turn_on;
    logic                             level1_good;
    logic                             level2_good;

    logic                             s_accept;
    logic                             m_accept;
    logic                             cfg_accept;
    logic                             bad_channel;

    dorc_pkg::chan_cmd_t              cmd  [CHANNELS];
    dorc_pkg::chan_stat_t             stat [CHANNELS];
    logic                             wr_en [CHANNELS];
    logic [CHANNELS-1:0]              applied_vec;
    logic [CHANNELS-1:0]              armed_vec;
    logic [dorc_pkg::RELAY_W-1:0]     relay_next;
    dorc_pkg::result_t                result;

    // Output stage: the head word drives the port, the skid word sits behind it.
    logic                             out_valid_reg,  out_valid_next;
    logic                             skid_valid_reg, skid_valid_next;
    dorc_pkg::result_t                out_reg,  out_next;
    dorc_pkg::result_t                skid_reg, skid_next;

    assign action      = dorc_pkg::action_t'(s_tuser);
    assign channel     = s_tdata[dorc_pkg::CHAN_W-1:0];
    assign turn_on     = s_tdata[3];
    assign level1_good = s_tdata[4];
    assign level2_good = s_tdata[5];

    // An input word is taken whenever the skid slot is free.
    assign s_tready   = !skid_valid_reg;
    assign s_accept   = s_tvalid && s_tready;
    assign m_accept   = m_tvalid && m_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    // A single request naming a channel that is not built is flagged and ignored.
    assign bad_channel = (action == dorc_pkg::ACT_REQUEST)
                      && ({1'b0, channel} >= (dorc_pkg::CHAN_W + 1)'(CHANNELS));

    // Per-channel decode and timer. A sensor update drives channels 0 and 1 with the
    // inverse of the first float sensor and channel 2 with the second one; when those
    // channels are not built the request simply has nowhere to go.
    for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
        localparam int IDX = i;

        always_comb begin
            cmd[i] = '0;
            if (s_accept) begin
                case (action)
                    dorc_pkg::ACT_TICK: begin
                        cmd[i].tick = 1'b1;
                    end
                    dorc_pkg::ACT_REQUEST: begin
                        if (channel == dorc_pkg::CHAN_W'(IDX)) begin
                            cmd[i].req = 1'b1;
                            cmd[i].on  = turn_on;
                        end
                    end
                    dorc_pkg::ACT_SENSOR: begin
                        if (IDX <= 1) begin
                            cmd[i].req = 1'b1;
                            cmd[i].on  = !level1_good;
                        end else if (IDX == 2) begin
                            cmd[i].req = 1'b1;
                            cmd[i].on  = level2_good;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        // Only the first channels have a delay register; the rest keep their fixed delay.
        if (IDX < dorc_pkg::REG_COUNT) begin : g_wr
            assign wr_en[i] = cfg_accept && (cfg_index == dorc_pkg::CFG_INDEX_W'(IDX));
        end else begin : g_no_wr
            assign wr_en[i] = 1'b0;
        end

        dorc_chan #(
            .RESET_DELAY (dorc_pkg::chan_reset_delay(IDX))
        ) u_chan (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd[i]),
            .wr_en   (wr_en[i]),
            .wr_data (cfg_data),
            .stat    (stat[i])
        );

        assign applied_vec[i] = stat[i].applied;
        assign armed_vec[i]   = stat[i].armed;
    end

    // Only the first four relays are reported; relays that are not built read as off.
    for (genvar b = 0; b < dorc_pkg::RELAY_W; b++) begin : g_relay
        if (b < CHANNELS) begin : g_used
            assign relay_next[b] = stat[b].applied_next;
        end else begin : g_unused
            assign relay_next[b] = 1'b0;
        end
    end

    assign result.relay = relay_next;
    assign result.bad   = bad_channel;

    // Output stage. When the head word leaves, the skid word moves up; no word is taken
    // while the skid is full. Otherwise a new word fills the first free slot.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (m_accept) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = s_accept;
                skid_next       = result;
            end else begin
                out_valid_next = s_accept;
                out_next       = result;
            end
        end else if (s_accept) begin
            if (!out_valid_reg) begin
                out_valid_next = 1'b1;
                out_next       = result;
            end else begin
                skid_valid_next = 1'b1;
                skid_next       = result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(dorc_pkg::M_TDATA_W - dorc_pkg::RELAY_W){1'b0}}, out_reg.relay};
    assign m_tuser  = out_reg.bad;

`ifndef SYNTHESIS
    // The skid slot is only ever used behind an occupied head slot.
    a_skid_behind_head: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with an empty head slot");

    // A channel is never armed and switched on at the same time.
    a_armed_xor_applied: assert property (@(posedge aclk) disable iff (!aresetn)
        (armed_vec & applied_vec) == '0)
        else $error("channel armed while its relay is on");

    // Relays only move when an input word is taken.
    a_relays_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(applied_vec))
        else $error("relay state changed without an input word");

    // A request to a channel that is not built leaves every relay and arming as it was.
    a_bad_request_no_effect: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && bad_channel)
        |=> (applied_vec == $past(applied_vec)) && (armed_vec == $past(armed_vec)))
        else $error("request to a missing channel changed state");
`endif

endmodule

FILE: dv/relay_timer_checker.sv
`timescale 1ns / 1ps

module relay_timer_checker
    import dorc_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [S_TDATA_W-1:0]    s_tdata,
    input  logic [ACTION_W-1:0]     s_tuser,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [M_TDATA_W-1:0]    m_tdata,
    input  logic [0:0]              m_tuser,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [DELAY_W-1:0]      cfg_data,
    output int                      pending_words,
    output int                      mismatches
);

    // Shadow copy of the channel timers.
    logic [CHANNELS_MAX-1:0] applied;
    logic [CHANNELS_MAX-1:0] armed;
    logic [DELAY_W-1:0]      delay_ticks [CHANNELS_MAX];
    logic [DELAY_W-1:0]      elapsed     [CHANNELS_MAX];

    result_t relay_words_due [$];

    task automatic request_channel(input int ch, input logic on);
        if (ch < CHANNELS) begin
            if (!on) begin
                armed[ch]   = 1'b0;
                applied[ch] = 1'b0;
            end else if (!applied[ch] && !armed[ch]) begin
                // A repeated on request must not restart a running delay.
                armed[ch]   = 1'b1;
                elapsed[ch] = '0;
            end
        end
    endtask

    task automatic count_tick();
        for (int i = 0; i < CHANNELS; i++) begin
            if (armed[i]) begin
                if (elapsed[i] != '1)
                    elapsed[i] = elapsed[i] + DELAY_W'(1);
                if (elapsed[i] >= delay_ticks[i]) begin
                    armed[i]   = 1'b0;
                    applied[i] = 1'b1;
                end
            end
        end
    endtask

    task automatic predict_word(input action_t act, input logic [CHAN_W-1:0] ch,
                                input logic on, input logic f1, input logic f2,
                                output result_t word);
        word.bad = 1'b0;
        case (act)
            ACT_TICK: begin
                count_tick();
            end
            ACT_REQUEST: begin
                if (ch >= CHANNELS)
                    word.bad = 1'b1;
                else
                    request_channel(ch, on);
            end
            ACT_SENSOR: begin
                request_channel(0, !f1);
                request_channel(1, !f1);
                request_channel(2, f2);
            end
            default: begin
            end
        endcase
        word.relay = applied[RELAY_W-1:0];
    endtask

    task automatic report_mismatch(input string what, input result_t want,
                                   input result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected relay %h bad %b, got relay %h bad %b",
                     $realtime, what, want.relay, want.bad, got.relay, got.bad);
    endtask

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            applied = '0;
            armed   = '0;
            for (int i = 0; i < CHANNELS_MAX; i++) begin
                delay_ticks[i] = (i < 3) ? DELAY_FAST : DELAY_SLOW;
                elapsed[i]     = '0;
            end
            relay_words_due.delete();
            mismatches    = 0;
            pending_words <= 0;
        end else begin
            if (cfg_valid && cfg_ready && cfg_index < REG_COUNT && cfg_index < CHANNELS)
                delay_ticks[cfg_index] = cfg_data;

            if (m_tvalid && m_tready) begin
                got.relay = m_tdata[RELAY_W-1:0];
                got.bad   = m_tuser[0];
                if (relay_words_due.size() == 0) begin
                    want = '0;
                    report_mismatch("result word with nothing outstanding", want, got);
                end else begin
                    want = relay_words_due.pop_front();
                    if (want.relay != got.relay || want.bad != got.bad)
                        report_mismatch("result word differs", want, got);
                end
            end

            if (s_tvalid && s_tready) begin
                predict_word(action_t'(s_tuser), s_tdata[2:0], s_tdata[3], s_tdata[4],
                             s_tdata[5], want);
                relay_words_due.push_back(want);
            end

            pending_words <= relay_words_due.size();
        end
    end

endmodule

FILE: dv/tb_delayed_on_relay_channels_core.sv
`timescale 1ns / 1ps

module tb_delayed_on_relay_channels_core;
    import dorc_pkg::*;

    // Cycle budget for the whole run; the watchdog ends the run when it runs out.
    localparam int CYCLE_LIMIT = 200000;
    // Length of the one long stall on the result side, in cycles.
    localparam int LONG_HOLD = 300;
    // Random words per phase.
    localparam int PHASE_WORDS = 150;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_DELAY_CH0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DELAY_CH1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DELAY_CH2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DELAY_CH3 = 3'd3;

    localparam logic [DELAY_W-1:0] DELAY_ZERO = '0;
    localparam logic [DELAY_W-1:0] DELAY_MAX  = '1;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // s_tdata, lowest bit first: channel [2:0], turn_on [3], level1_good [4],
    // level2_good [5], zero padding [7:6].
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    // s_tuser: action [1:0].
    logic [ACTION_W-1:0]    s_tuser   = ACT_TICK;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // m_tdata, lowest bit first: relay_bits [3:0], zero padding [7:4].
    logic [M_TDATA_W-1:0]   m_tdata;
    // m_tuser: bad_channel [0].
    logic [0:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DELAY_W-1:0]     cfg_data  = '0;

    int pending_words;
    int mismatches;
    int cycle_count = 0;

    // Set for the closing phase: from then on neither side idles.
    bit calm = 1'b0;
    // Raised by the stimulus to ask the result side for its long stall.
    bit hold_request = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    delayed_on_relay_channels_core #(
        .CHANNELS (CHANNELS_DEFAULT)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The checker shadows the timers, predicts each result word and compares.
    relay_timer_checker #(
        .CHANNELS (CHANNELS_DEFAULT)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending_words (pending_words),
        .mismatches    (mismatches)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("delayed_on_relay_channels_core: mismatch");
            $finish;
        end
    end

    // Offers one input word and holds it until it is taken. Valid is left high
    // afterwards unless an idle burst follows, so that back-to-back words never
    // see valid lowered and raised within the same time step.
    task automatic send_word(input action_t act, input logic [CHAN_W-1:0] ch,
                             input logic on, input logic f1, input logic f2);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {2'b00, f2, f1, on, ch};
        do @(posedge aclk); while (!s_tready);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    // Random word: ticks dominate so that armed channels actually reach their
    // delay; most single requests name a real channel, some name a bad one,
    // and the spare action code turns up now and then.
    task automatic send_random_word();
        int            roll;
        action_t       act;
        logic [CHAN_W-1:0] ch;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            act = ACT_TICK;
        else if (roll < 75)
            act = ACT_REQUEST;
        else if (roll < 93)
            act = ACT_SENSOR;
        else
            act = ACT_SPARE;
        if ($urandom_range(0, 4) == 0)
            ch = CHAN_W'($urandom_range(4, 7));
        else
            ch = CHAN_W'($urandom_range(0, 3));
        send_word(act, ch, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic run_random(input int count);
        repeat (count) send_random_word();
    endtask

    // Stops offering and waits until every predicted word has come back,
    // then lets the two-entry output stage go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_words != 0);
        repeat (4) @(posedge aclk);
    endtask

    // One register write; valid drops for a cycle afterwards.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DELAY_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_delays(input logic [DELAY_W-1:0] d0, input logic [DELAY_W-1:0] d1,
                              input logic [DELAY_W-1:0] d2, input logic [DELAY_W-1:0] d3);
        write_reg(REG_DELAY_CH0, d0);
        write_reg(REG_DELAY_CH1, d1);
        write_reg(REG_DELAY_CH2, d2);
        write_reg(REG_DELAY_CH3, d3);
    endtask

    // Writes to indexes beyond the register file must be ignored.
    task automatic write_unused_regs();
        for (int r = REG_COUNT; r < 2 ** CFG_INDEX_W; r++)
            write_reg(CFG_INDEX_W'(r), DELAY_W'($urandom_range(0, 65535)));
    endtask

    // Result side: random bursts of ready and stall, one long stall on request,
    // and steady ready in the closing phase. Exactly one assignment per edge.
    initial begin
        int span;
        bit level;
        wait (aresetn);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                repeat (LONG_HOLD) begin
                    m_tready <= 1'b0;
                    @(posedge aclk);
                end
            end else if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                span  = $urandom_range(1, 9);
                level = ($urandom_range(0, 9) < 7);
                repeat (span) begin
                    m_tready <= level;
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words with the reset delays of 50, 50, 50 and 1000 ticks.
        send_word(ACT_SPARE,   3'd7, 1'b1, 1'b1, 1'b1);  // spare code leaves everything alone
        send_word(ACT_REQUEST, 3'd4, 1'b1, 1'b0, 1'b0);  // first invalid channel
        send_word(ACT_REQUEST, 3'd7, 1'b0, 1'b1, 1'b1);  // last invalid channel
        send_word(ACT_TICK,    3'd0, 1'b0, 1'b0, 1'b0);  // tick with nothing armed
        send_word(ACT_REQUEST, 3'd0, 1'b1, 1'b0, 1'b0);  // arm channel 0
        send_word(ACT_TICK,    3'd5, 1'b1, 1'b1, 1'b1);
        send_word(ACT_REQUEST, 3'd0, 1'b1, 1'b0, 1'b0);  // repeat must not restart the count
        send_word(ACT_REQUEST, 3'd3, 1'b1, 1'b0, 1'b0);
        send_word(ACT_SENSOR,  3'd0, 1'b0, 1'b0, 1'b1);  // arm channels 1 and 2; channel 0 stays armed
        send_word(ACT_SENSOR,  3'd7, 1'b1, 1'b1, 1'b0);  // switch channels 0, 1 and 2 off
        send_word(ACT_SENSOR,  3'd0, 1'b0, 1'b0, 1'b0);
        send_word(ACT_REQUEST, 3'd1, 1'b0, 1'b0, 1'b0);
        send_word(ACT_REQUEST, 3'd2, 1'b1, 1'b0, 1'b0);
        run_random(PHASE_WORDS);
        settle();

        // Zero delays: an armed channel comes on at the very next tick. The
        // result side also takes its long stall here while words keep coming.
        set_delays(DELAY_ZERO, DELAY_ZERO, DELAY_ZERO, DELAY_ZERO);
        write_unused_regs();
        send_word(ACT_REQUEST, 3'd0, 1'b1, 1'b0, 1'b0);
        send_word(ACT_TICK,    3'd0, 1'b0, 1'b0, 1'b0);
        send_word(ACT_REQUEST, 3'd0, 1'b1, 1'b0, 1'b0);  // already on, so no new arming
        send_word(ACT_REQUEST, 3'd0, 1'b0, 1'b0, 1'b0);
        send_word(ACT_TICK,    3'd0, 1'b0, 1'b0, 1'b0);
        hold_request = 1'b1;
        run_random(PHASE_WORDS);
        settle();

        // Largest delays: channels stay armed for the whole phase.
        set_delays(DELAY_MAX, DELAY_MAX, DELAY_MAX, DELAY_MAX);
        write_unused_regs();
        run_random(PHASE_WORDS);
        settle();

        // Short random delays, so that channels switch on often.
        set_delays(DELAY_W'($urandom_range(1, 6)), DELAY_W'($urandom_range(1, 6)),
                   DELAY_W'($urandom_range(1, 6)), DELAY_W'($urandom_range(1, 6)));
        run_random(PHASE_WORDS);
        settle();

        // A mix of extremes and short delays across the channels.
        set_delays(16'd1, DELAY_MAX, DELAY_ZERO, 16'd7);
        run_random(PHASE_WORDS);
        settle();

        // Closing phase without idling on either side.
        calm = 1'b1;
        set_delays(DELAY_W'($urandom_range(0, 10)), DELAY_W'($urandom_range(0, 10)),
                   DELAY_W'($urandom_range(0, 10)), DELAY_W'($urandom_range(0, 10)));
        run_random(PHASE_WORDS);
        settle();

        if (mismatches == 0)
            $display("delayed_on_relay_channels_core: match");
        else
            $display("delayed_on_relay_channels_core: mismatch");
        $finish;
    end

endmodule
